[rtl/dimx_pkg.sv]
// shared types, constants and helpers of the dual-index read demultiplexer
package dimx_pkg;

  localparam int MAX_BARCODES_DEF  = 64;
  localparam int BARCODE_BASES_DEF = 8;
  localparam int MAX_READ_LEN_DEF  = 512;

  localparam int PHRED_OFFSET = 33;

  localparam logic ACT_LOAD     = 1'b0;
  localparam logic ACT_POSITION = 1'b1;

  localparam logic [1:0] CAT_MATCHED = 2'd0;
  localparam logic [1:0] CAT_UNKNOWN = 2'd1;
  localparam logic [1:0] CAT_HOPPED  = 2'd2;

  localparam logic REG_QUALITY_CUTOFF  = 1'b0;
  localparam logic REG_BARCODES_IN_USE = 1'b1;

  localparam logic [6:0] QUALITY_CUTOFF_RST  = 7'd30;
  localparam logic [6:0] BARCODES_IN_USE_RST = 7'd24;

  typedef struct packed {
    logic load;
    logic accum;
    logic qual;
    logic scan;
    logic emit;
  } dimx_cmd_t;

  typedef struct packed {
    logic reject;
    logic scan_done;
    logic out_free;
  } dimx_sts_t;

  // complement of one base character
  function automatic logic [7:0] pair_of(input logic [7:0] ch);
    logic [7:0] r;
    case (ch)
      "A":      r = "T";
      "a":      r = "t";
      "T", "U": r = "A";
      "t", "u": r = "a";
      "C":      r = "G";
      "c":      r = "g";
      "G":      r = "C";
      "g":      r = "c";
      "N":      r = "N";
      "n":      r = "n";
      " ":      r = " ";
      default:  r = 8'd0;
    endcase
    return r;
  endfunction

endpackage

[rtl/dimx_table.sv]
// barcode table: forward code and reverse complement per slot, registered read
module dimx_table #(
  parameter int MAX_BARCODES  = dimx_pkg::MAX_BARCODES_DEF,
  parameter int BARCODE_BASES = dimx_pkg::BARCODE_BASES_DEF,
  localparam int PW = 8 * BARCODE_BASES,
  localparam int IW = (MAX_BARCODES > 1) ? $clog2(MAX_BARCODES) : 1
) (
  input  logic          clk,
  input  logic          wr_en,
  input  logic [IW-1:0] wr_addr,
  input  logic [PW-1:0] wr_code,
  input  logic          rd_en,
  input  logic [IW-1:0] rd_addr,
  output logic [PW-1:0] rd_fwd,
  output logic [PW-1:0] rd_rc
);

  logic [2*PW-1:0] mem [MAX_BARCODES];
  logic [2*PW-1:0] rd_data;
  logic [PW-1:0]   rc_code;

  // lowest byte of the code becomes the highest byte of its reverse complement
  for (genvar i = 0; i < BARCODE_BASES; i++) begin : g_rc
    assign rc_code[PW-1-8*i -: 8] = dimx_pkg::pair_of(wr_code[8*i +: 8]);
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= {wr_code, rc_code};
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

  assign rd_fwd = rd_data[2*PW-1:PW];
  assign rd_rc  = rd_data[PW-1:0];

endmodule

[rtl/dimx_datapath.sv]
// per-pair accumulators, quality check, table scan and result register
module dimx_datapath #(
  parameter int MAX_BARCODES  = dimx_pkg::MAX_BARCODES_DEF,
  parameter int BARCODE_BASES = dimx_pkg::BARCODE_BASES_DEF,
  parameter int MAX_READ_LEN  = dimx_pkg::MAX_READ_LEN_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  dimx_pkg::dimx_cmd_t cmd,
  output dimx_pkg::dimx_sts_t sts,
  input  logic [5:0]          slot,
  input  logic [63:0]         barcode_text,
  input  logic [7:0]          fwd_base,
  input  logic [7:0]          rev_base,
  input  logic [7:0]          fwd_quality,
  input  logic [7:0]          rev_quality,
  input  logic [6:0]          quality_cutoff,
  input  logic [6:0]          barcodes_in_use,
  input  logic                out_ready,
  output logic                out_valid,
  output logic [1:0]          category,
  output logic [5:0]          matched_slot
);

  localparam int PW     = 8 * BARCODE_BASES;
  localparam int IW     = (MAX_BARCODES > 1) ? $clog2(MAX_BARCODES) : 1;
  localparam int NW0    = $clog2(MAX_BARCODES + 1);
  localparam int NW     = (NW0 > 7) ? NW0 : 7;
  localparam int SW     = (IW > 6) ? IW : 6;
  localparam int CNT_W  = $clog2(MAX_READ_LEN + 1);
  localparam int SUM_W  = CNT_W + 8;

  logic [CNT_W-1:0] position_count;
  logic [SUM_W-1:0] fwd_quality_sum;
  logic [SUM_W-1:0] rev_quality_sum;
  logic [PW-1:0]    fwd_prefix;
  logic [PW-1:0]    rev_prefix;
  logic [1:0]       space_flags;

  logic             reject;
  logic [NW-1:0]    scan_addr;
  logic             rd_pend;
  logic [IW-1:0]    rd_idx;
  logic             found_f;
  logic             found_r;
  logic             rc_at_j;
  logic [IW-1:0]    match_idx;

  logic [NW-1:0]    n_lim;
  logic             issue;
  logic [PW-1:0]    rd_fwd;
  logic [PW-1:0]    rd_rc;
  logic             fmatch;
  logic             rmatch;
  logic [SW-1:0]    slot_ext;
  logic             slot_ok;
  logic [7:0]       thr;
  logic [SUM_W-1:0] thr_prod_f;
  logic [SUM_W-1:0] thr_prod_r;
  logic [SUM_W-1:0] floor32;
  logic             low_f;
  logic             low_r;
  logic             short_read;
  logic [1:0]       cat_next;
  logic [5:0]       slot_next;
  logic [SW-1:0]    match_ext;

  assign slot_ext = SW'(slot);
  assign slot_ok  = 32'(slot) < 32'(MAX_BARCODES);

  dimx_table #(
    .MAX_BARCODES (MAX_BARCODES),
    .BARCODE_BASES(BARCODE_BASES)
  ) u_table (
    .clk    (clk),
    .wr_en  (cmd.load && slot_ok),
    .wr_addr(slot_ext[IW-1:0]),
    .wr_code(barcode_text[63 -: PW]),
    .rd_en  (issue),
    .rd_addr(scan_addr[IW-1:0]),
    .rd_fwd (rd_fwd),
    .rd_rc  (rd_rc)
  );

  // per-pair accumulation; positions past the read length limit are dropped
  always_ff @(posedge clk) begin
    if (rst || cmd.emit) begin
      position_count  <= '0;
      fwd_quality_sum <= '0;
      rev_quality_sum <= '0;
      fwd_prefix      <= '0;
      rev_prefix      <= '0;
      space_flags     <= '0;
    end else if (cmd.accum && position_count < CNT_W'(MAX_READ_LEN)) begin
      if (position_count < CNT_W'(BARCODE_BASES)) begin
        fwd_prefix <= {fwd_prefix[PW-9:0], fwd_base};
        rev_prefix <= {rev_prefix[PW-9:0], rev_base};
      end
      if (fwd_quality == " ") space_flags[0] <= 1'b1;
      if (rev_quality == " ") space_flags[1] <= 1'b1;
      fwd_quality_sum <= fwd_quality_sum + SUM_W'(fwd_quality);
      rev_quality_sum <= rev_quality_sum + SUM_W'(rev_quality);
      position_count  <= position_count + CNT_W'(1);
    end
  end

  // truncated average below cutoff, without a divider:
  // cutoff 0 needs avg <= -1, i.e. sum <= 32*count; otherwise sum < (33+cutoff)*count
  assign thr        = 8'(quality_cutoff) + 8'(dimx_pkg::PHRED_OFFSET);
  assign thr_prod_f = SUM_W'(thr) * SUM_W'(position_count);
  assign thr_prod_r = thr_prod_f;
  assign floor32    = SUM_W'(position_count) << 5;
  assign short_read = position_count < CNT_W'(BARCODE_BASES);

  always_comb begin
    if (space_flags[0]) begin
      low_f = quality_cutoff != 7'd0;
    end else if (quality_cutoff == 7'd0) begin
      low_f = fwd_quality_sum <= floor32;
    end else begin
      low_f = fwd_quality_sum < thr_prod_f;
    end
    if (space_flags[1]) begin
      low_r = quality_cutoff != 7'd0;
    end else if (quality_cutoff == 7'd0) begin
      low_r = rev_quality_sum <= floor32;
    end else begin
      low_r = rev_quality_sum < thr_prod_r;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      reject <= 1'b0;
    end else if (cmd.qual) begin
      reject <= short_read || low_f || low_r;
    end
  end

  // one slot read per cycle, compared in the next cycle
  assign n_lim  = (NW'(barcodes_in_use) > NW'(MAX_BARCODES)) ? NW'(MAX_BARCODES)
                                                             : NW'(barcodes_in_use);
  assign issue  = cmd.scan && scan_addr < n_lim;
  assign fmatch = rd_fwd == fwd_prefix;
  assign rmatch = rd_rc == rev_prefix;

  always_ff @(posedge clk) begin
    if (rst) begin
      scan_addr <= '0;
      rd_pend   <= 1'b0;
      found_f   <= 1'b0;
      found_r   <= 1'b0;
      rc_at_j   <= 1'b0;
    end else if (cmd.qual) begin
      scan_addr <= '0;
      rd_pend   <= 1'b0;
      found_f   <= 1'b0;
      found_r   <= 1'b0;
      rc_at_j   <= 1'b0;
    end else begin
      rd_pend <= issue;
      if (issue) begin
        scan_addr <= scan_addr + NW'(1);
      end
      if (rd_pend) begin
        if (fmatch && !found_f) begin
          found_f <= 1'b1;
          rc_at_j <= rmatch;
        end
        if (rmatch) begin
          found_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (issue) begin
      rd_idx <= scan_addr[IW-1:0];
    end
    if (rd_pend && fmatch && !found_f) begin
      match_idx <= rd_idx;
    end
  end

  assign match_ext = SW'(match_idx);

  always_comb begin
    cat_next  = dimx_pkg::CAT_UNKNOWN;
    slot_next = 6'd0;
    if (!reject && found_f) begin
      if (rc_at_j) begin
        cat_next  = dimx_pkg::CAT_MATCHED;
        slot_next = match_ext[5:0];
      end else if (found_r) begin
        cat_next = dimx_pkg::CAT_HOPPED;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      category     <= cat_next;
      matched_slot <= slot_next;
    end
  end

  assign sts.reject    = reject;
  assign sts.scan_done = !(scan_addr < n_lim) && !rd_pend;
  assign sts.out_free  = !out_valid || out_ready;

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    position_count <= CNT_W'(MAX_READ_LEN))
    else $error("position count past read length limit");

  a_slot_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && category != dimx_pkg::CAT_MATCHED |-> matched_slot == 6'd0)
    else $error("slot reported on a pair that did not match");

  a_cleared: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |=> position_count == '0 && space_flags == 2'b00)
    else $error("pair state not cleared after result");

endmodule

[rtl/dimx_ctrl.sv]
// sequencing of load, position, quality check, table scan and result
module dimx_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic                action,
  input  logic                last_position,
  input  dimx_pkg::dimx_sts_t sts,
  output dimx_pkg::dimx_cmd_t cmd
);

  typedef enum logic [3:0] {
    ST_IDLE   = 4'b0001,
    ST_QUAL   = 4'b0010,
    ST_SCAN   = 4'b0100,
    ST_RESULT = 4'b1000
  } dimx_state_t;

  dimx_state_t state;
  dimx_state_t state_next;
  logic        accept;

  assign in_ready = state == ST_IDLE;
  assign accept   = in_valid && in_ready;

  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      ST_IDLE: begin
        cmd.load  = accept && action == dimx_pkg::ACT_LOAD;
        cmd.accum = accept && action == dimx_pkg::ACT_POSITION;
        if (cmd.accum && last_position) begin
          state_next = ST_QUAL;
        end
      end
      ST_QUAL: begin
        cmd.qual   = 1'b1;
        state_next = ST_SCAN;
      end
      ST_SCAN: begin
        cmd.scan = 1'b1;
        if (sts.reject || sts.scan_done) begin
          state_next = ST_RESULT;
        end
      end
      ST_RESULT: begin
        if (sts.out_free) begin
          cmd.emit   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  a_emit_free: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |-> sts.out_free)
    else $error("result written over one not yet taken");

  a_last_starts: assert property (@(posedge clk) disable iff (rst)
    accept && action == dimx_pkg::ACT_POSITION && last_position |=> state == ST_QUAL)
    else $error("last position did not start classification");

  a_result_once: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |=> !cmd.emit)
    else $error("two results for one pair");

endmodule

[rtl/dual_index_read_demultiplexer_top.sv]
// top level: stream ports, configuration registers, controller and datapath
//
// Classifies dual-indexed read pairs against a loaded barcode table. A load
// item (tuser 0) writes one slot. A position item (tuser 1) is accumulated
// into the current pair. After the position item marked by tlast the block
// stops taking items while it works on the pair: the quality check, then a
// scan of n slots (barcodes_in_use, capped at MAX_BARCODES) through the table's
// single read port at one slot per cycle, then the last compare, then the write
// of the result to the output register. A pair rejected as too short or of low
// quality skips the scan, as does a pair with no slot searched. The result
// waits in the output register, so new items are taken while it is still
// unread; the next pair's result is held back, with the input stopped, until
// the earlier one is taken.
// Registers: 0x0 quality_cutoff, 0x4 barcodes_in_use.
module dual_index_read_demultiplexer_top #(
  parameter int MAX_BARCODES  = dimx_pkg::MAX_BARCODES_DEF,
  parameter int BARCODE_BASES = dimx_pkg::BARCODE_BASES_DEF,
  parameter int MAX_READ_LEN  = dimx_pkg::MAX_READ_LEN_DEF
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // slot[5:0], barcode_text[69:6], fwd_base[77:70], rev_base[85:78],
  // fwd_quality[93:86], rev_quality[101:94], zero[103:102]
  input  logic [103:0] s_axis_tdata,
  // action[0]
  input  logic         s_axis_tuser,
  input  logic         s_axis_tlast,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // matched_slot[5:0], zero[7:6]
  output logic [7:0]   m_axis_tdata,
  // category[1:0]
  output logic [1:0]   m_axis_tuser,
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic [2:0]   paddr,
  input  logic [31:0]  pwdata,
  output logic [31:0]  prdata,
  output logic         pready
);

  logic [6:0]          quality_cutoff;
  logic [6:0]          barcodes_in_use;
  logic                cfg_wr;
  logic [5:0]          matched_slot;
  dimx_pkg::dimx_cmd_t cmd;
  dimx_pkg::dimx_sts_t sts;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      quality_cutoff  <= dimx_pkg::QUALITY_CUTOFF_RST;
      barcodes_in_use <= dimx_pkg::BARCODES_IN_USE_RST;
    end else if (cfg_wr) begin
      case (paddr[2])
        dimx_pkg::REG_QUALITY_CUTOFF:  quality_cutoff  <= pwdata[6:0];
        dimx_pkg::REG_BARCODES_IN_USE: barcodes_in_use <= pwdata[6:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      dimx_pkg::REG_QUALITY_CUTOFF:  prdata = {25'd0, quality_cutoff};
      dimx_pkg::REG_BARCODES_IN_USE: prdata = {25'd0, barcodes_in_use};
      default:                       prdata = 32'd0;
    endcase
  end

  dimx_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (s_axis_tvalid),
    .in_ready     (s_axis_tready),
    .action       (s_axis_tuser),
    .last_position(s_axis_tlast),
    .sts          (sts),
    .cmd          (cmd)
  );

  dimx_datapath #(
    .MAX_BARCODES (MAX_BARCODES),
    .BARCODE_BASES(BARCODE_BASES),
    .MAX_READ_LEN (MAX_READ_LEN)
  ) u_datapath (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .sts            (sts),
    .slot           (s_axis_tdata[5:0]),
    .barcode_text   (s_axis_tdata[69:6]),
    .fwd_base       (s_axis_tdata[77:70]),
    .rev_base       (s_axis_tdata[85:78]),
    .fwd_quality    (s_axis_tdata[93:86]),
    .rev_quality    (s_axis_tdata[101:94]),
    .quality_cutoff (quality_cutoff),
    .barcodes_in_use(barcodes_in_use),
    .out_ready      (m_axis_tready),
    .out_valid      (m_axis_tvalid),
    .category       (m_axis_tuser),
    .matched_slot   (matched_slot)
  );

  assign m_axis_tdata = {2'b00, matched_slot};

endmodule
